FILE: rtl/core/sas_pkg.sv
`default_nettype none

package sas_pkg;

    localparam int MAX_ARGS = 255;
    localparam int CountCapInt = (MAX_ARGS < 255) ? MAX_ARGS : 255;
    localparam logic [7:0] COUNT_CAP = 8'(CountCapInt);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_BSL  = 8'h5c;
    localparam logic [7:0] CH_LC_N = 8'h6e;
    localparam logic [7:0] CH_LC_T = 8'h74;

    localparam logic [23:0] WORD_ENV      = 24'h656e76;
    localparam logic [31:0] WORD_SLASHENV = 32'h2f656e76;

    typedef enum logic [3:0] {
        PH_HASH      = 4'd0,
        PH_BANG      = 4'd1,
        PH_DISCARD   = 4'd2,
        PH_LEAD      = 4'd3,
        PH_INTERP    = 4'd4,
        PH_ENV_BLANK = 4'd5,
        PH_ENV_WORD  = 4'd6,
        PH_NORMAL    = 4'd7,
        PH_SQ        = 4'd8,
        PH_DQ        = 4'd9,
        PH_DQ_ESC    = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] count;
    } res_t;

    // One queued command: one or two results from a single input byte
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/shebang_argument_splitter.sv
`default_nettype none

// Shebang argument splitter: takes a "#!" line one byte per beat (byte 0 ends
// the line), skips the interpreter word (and the word after an "env"
// interpreter) and streams the remaining arguments as byte, end-of-argument,
// done and unterminated-quote beats, with a saturating argument count and a
// last flag on the final beat that a byte causes. The front accepts one byte
// every cycle while the four-entry command queue has room; the output stage
// sends one result beat per cycle while the receiver is ready, and does not
// read the queue while the second result of a byte is still held. Each result
// passes through the command queue and then the output register. The block is
// ready for a new line straight after done or error.
module shebang_argument_splitter
    import sas_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_value,
    output logic [7:0]      m_count,
    output logic            m_last
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic empty;
    logic full;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    sas_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_ch),
        .push    (push),
        .cmd     (push_cmd)
    );

    sas_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    sas_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_value (m_value),
        .m_count (m_count),
        .m_last  (m_last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/sas_front.sv
`default_nettype none

module sas_front
    import sas_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] ch,
    output logic            push,
    output cmd_t            cmd
);

    phase_t      phase_reg, phase_next;
    logic        in_arg_reg, in_arg_next;
    logic [31:0] tail_reg, tail_next;
    logic [2:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;

    logic        blank;
    logic        is_env;
    logic [7:0]  cnt_inc;
    logic        n_res;
    logic        new_line;

    assign blank   = (ch == CH_SP) || (ch == CH_TAB);
    assign is_env  = ((len_reg == 3'd3) && (tail_reg[23:0] == WORD_ENV))
                   || ((len_reg >= 3'd4) && (tail_reg == WORD_SLASHENV));
    assign cnt_inc = (cnt_reg < COUNT_CAP) ? cnt_reg + 8'd1 : cnt_reg;

    always_comb begin
        phase_next = phase_reg;
        in_arg_next = in_arg_reg;
        tail_next = tail_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        new_line = 1'b0;
        n_res = 1'b0;
        cmd = '{two: 1'b0,
                r0: '{kind: KIND_DONE, value: 8'd0, count: cnt_reg},
                r1: '{kind: KIND_DONE, value: 8'd0, count: cnt_reg}};

        unique case (phase_reg)
            PH_HASH, PH_BANG: begin
                if (ch == ((phase_reg == PH_HASH) ? CH_HASH : CH_BANG)) begin
                    phase_next = (phase_reg == PH_HASH) ? PH_BANG : PH_LEAD;
                end else begin
                    n_res = 1'b1;
                    new_line = 1'b1;
                end
            end
            PH_DISCARD: begin
                if (ch == CH_NUL) begin
                    new_line = 1'b1;
                end
            end
            PH_LEAD: begin
                if (ch == CH_NUL) begin
                    n_res = 1'b1;
                    new_line = 1'b1;
                end else if (!blank) begin
                    tail_next = {24'd0, ch};
                    len_next = 3'd1;
                    phase_next = PH_INTERP;
                end
            end
            PH_INTERP: begin
                if (ch == CH_NUL) begin
                    n_res = 1'b1;
                    new_line = 1'b1;
                end else if (blank) begin
                    phase_next = is_env ? PH_ENV_BLANK : PH_NORMAL;
                end else begin
                    tail_next = {tail_reg[23:0], ch};
                    if (len_reg < 3'd5) begin
                        len_next = len_reg + 3'd1;
                    end
                end
            end
            PH_ENV_BLANK, PH_ENV_WORD: begin
                if (ch == CH_NUL) begin
                    n_res = 1'b1;
                    new_line = 1'b1;
                end else if (!blank) begin
                    phase_next = PH_ENV_WORD;
                end else if (phase_reg == PH_ENV_WORD) begin
                    phase_next = PH_NORMAL;
                end
            end
            PH_NORMAL: begin
                if (ch == CH_NUL) begin
                    n_res = 1'b1;
                    new_line = 1'b1;
                    if (in_arg_reg) begin
                        // close the open argument, then report done
                        cmd.two = 1'b1;
                        cmd.r0 = '{kind: KIND_END, value: 8'd0, count: cnt_inc};
                        cmd.r1 = '{kind: KIND_DONE, value: 8'd0, count: cnt_inc};
                    end
                end else if (blank) begin
                    if (in_arg_reg) begin
                        n_res = 1'b1;
                        cmd.r0 = '{kind: KIND_END, value: 8'd0, count: cnt_inc};
                        cnt_next = cnt_inc;
                        in_arg_next = 1'b0;
                    end
                end else if (ch == CH_SQ) begin
                    in_arg_next = 1'b1;
                    phase_next = PH_SQ;
                end else if (ch == CH_DQ) begin
                    in_arg_next = 1'b1;
                    phase_next = PH_DQ;
                end else begin
                    in_arg_next = 1'b1;
                    n_res = 1'b1;
                    cmd.r0 = '{kind: KIND_BYTE, value: ch, count: cnt_reg};
                end
            end
            PH_SQ: begin
                n_res = (ch != CH_SQ);
                if (ch == CH_NUL) begin
                    cmd.r0.kind = KIND_ERR;
                    new_line = 1'b1;
                end else if (ch == CH_SQ) begin
                    phase_next = PH_NORMAL;
                end else begin
                    cmd.r0 = '{kind: KIND_BYTE, value: ch, count: cnt_reg};
                end
            end
            PH_DQ: begin
                if (ch == CH_NUL) begin
                    n_res = 1'b1;
                    cmd.r0.kind = KIND_ERR;
                    new_line = 1'b1;
                end else if (ch == CH_DQ) begin
                    phase_next = PH_NORMAL;
                end else if (ch == CH_BSL) begin
                    phase_next = PH_DQ_ESC;
                end else begin
                    n_res = 1'b1;
                    cmd.r0 = '{kind: KIND_BYTE, value: ch, count: cnt_reg};
                end
            end
            PH_DQ_ESC: begin
                phase_next = PH_DQ;
                n_res = 1'b1;
                cmd.r0 = '{kind: KIND_BYTE, value: ch, count: cnt_reg};
                if (ch == CH_NUL) begin
                    // dangling backslash, then the quote error
                    cmd.two = 1'b1;
                    cmd.r0.value = CH_BSL;
                    cmd.r1 = '{kind: KIND_ERR, value: 8'd0, count: cnt_reg};
                    new_line = 1'b1;
                end else if (ch == CH_LC_N) begin
                    cmd.r0.value = CH_LF;
                end else if (ch == CH_LC_T) begin
                    cmd.r0.value = CH_TAB;
                end else if ((ch != CH_DQ) && (ch != CH_BSL)) begin
                    // unknown escape: keep both bytes
                    cmd.two = 1'b1;
                    cmd.r0.value = CH_BSL;
                    cmd.r1 = '{kind: KIND_BYTE, value: ch, count: cnt_reg};
                end
            end
            default: begin
                new_line = 1'b1;
            end
        endcase

        if (new_line) begin
            phase_next = PH_HASH;
            in_arg_next = 1'b0;
            tail_next = 32'd0;
            len_next = 3'd0;
            cnt_next = 8'd0;
            // a broken prefix on a non-null byte drops the rest of the line
            if (((phase_reg == PH_HASH) || (phase_reg == PH_BANG)) && n_res
                && (ch != CH_NUL)) begin
                phase_next = PH_DISCARD;
            end
        end
    end

    assign push = accept && n_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HASH;
            in_arg_reg <= 1'b0;
            tail_reg <= 32'd0;
            len_reg <= 3'd0;
            cnt_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            in_arg_reg <= in_arg_next;
            tail_reg <= tail_next;
            len_reg <= len_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sas_queue.sv
`default_nettype none

module sas_queue
    import sas_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign empty = (fill_reg == QCNT_W'(0));
    assign full  = (fill_reg == QCNT_W'(QDEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sas_back.sv
`default_nettype none

module sas_back
    import sas_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cmd_t       head,
    input  wire logic       empty,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_value,
    output logic [7:0]      m_count,
    output logic            m_last
);

    logic valid_reg, valid_next;
    res_t out_reg, out_next;
    logic last_reg, last_next;
    logic sec_pend_reg, sec_pend_next;
    res_t sec_reg, sec_next;
    logic load;

    assign load = !valid_reg || m_ready;
    assign pop  = load && !sec_pend_reg && !empty;

    always_comb begin
        valid_next = valid_reg;
        out_next = out_reg;
        last_next = last_reg;
        sec_pend_next = sec_pend_reg;
        sec_next = sec_reg;
        if (load) begin
            if (sec_pend_reg) begin
                // drain the held second result first
                valid_next = 1'b1;
                out_next = sec_reg;
                last_next = 1'b1;
                sec_pend_next = 1'b0;
            end else if (!empty) begin
                valid_next = 1'b1;
                out_next = head.r0;
                last_next = !head.two;
                sec_pend_next = head.two;
                sec_next = head.r1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sec_pend_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sec_pend_reg <= sec_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        last_reg <= last_next;
        sec_reg <= sec_next;
    end

    assign m_valid = valid_reg;
    assign m_kind  = out_reg.kind;
    assign m_value = out_reg.value;
    assign m_count = out_reg.count;
    assign m_last  = last_reg;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
    import sas_pkg::*;

    localparam int ITEM_TARGET = 1950;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] count;
        logic       last;
    } beat_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_ch;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_value;
    logic [7:0] m_count;
    logic       m_last;

    // splitter state as predicted from the accepted bytes
    phase_t      line_phase;
    logic        arg_open;
    logic [31:0] interp_tail;
    logic [2:0]  interp_len;
    logic [7:0]  arg_count;

    beat_t       expected_beats[$];
    beat_t       head_beat;
    logic [7:0]  line_bytes[$];
    int          items_sent = 0;
    int          failures = 0;
    int          tx_idle_max = 0;
    int          rx_idle_max = 0;
    int          rx_gap_left = 0;
    int          rx_hold_left = 0;
    int          hold_request = 0;

    shebang_argument_splitter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_ch    (s_ch),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_value (m_value),
        .m_count (m_count),
        .m_last  (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[shebang_argument_splitter] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic void restart_line();
        line_phase  = PH_HASH;
        arg_open    = 1'b0;
        interp_tail = '0;
        interp_len  = '0;
        arg_count   = '0;
    endfunction

    function automatic void push_beat(kind_t k, logic [7:0] v);
        beat_t b;
        b.kind  = k;
        b.value = (k == KIND_BYTE) ? v : 8'h00;
        b.count = arg_count;
        b.last  = 1'b0;
        expected_beats.push_back(b);
    endfunction

    function automatic void finish_line(kind_t k);
        push_beat(k, 8'h00);
        restart_line();
    endfunction

    function automatic void close_argument();
        if (arg_count < COUNT_CAP) arg_count++;
        arg_open = 1'b0;
        push_beat(KIND_END, 8'h00);
    endfunction

    function automatic bit interp_is_env();
        return (interp_len == 3'd3 && interp_tail[23:0] == WORD_ENV) ||
               (interp_len >= 3'd4 && interp_tail == WORD_SLASHENV);
    endfunction

    function automatic void split_byte(logic [7:0] c);
        int queued;
        queued = expected_beats.size();
        case (line_phase)
            PH_HASH, PH_BANG: begin
                if (c == ((line_phase == PH_HASH) ? CH_HASH : CH_BANG)) begin
                    line_phase = (line_phase == PH_HASH) ? PH_BANG : PH_LEAD;
                end else begin
                    finish_line(KIND_DONE);
                    if (c != CH_NUL) line_phase = PH_DISCARD;
                end
            end
            PH_DISCARD: begin
                if (c == CH_NUL) restart_line();
            end
            PH_LEAD: begin
                if (c == CH_NUL) begin
                    finish_line(KIND_DONE);
                end else if (!is_blank(c)) begin
                    interp_tail = {24'h0, c};
                    interp_len  = 3'd1;
                    line_phase  = PH_INTERP;
                end
            end
            PH_INTERP: begin
                if (c == CH_NUL) begin
                    finish_line(KIND_DONE);
                end else if (is_blank(c)) begin
                    line_phase = interp_is_env() ? PH_ENV_BLANK : PH_NORMAL;
                end else begin
                    interp_tail = {interp_tail[23:0], c};
                    if (interp_len < 3'd5) interp_len++;
                end
            end
            PH_ENV_BLANK, PH_ENV_WORD: begin
                if (c == CH_NUL) finish_line(KIND_DONE);
                else if (!is_blank(c)) line_phase = PH_ENV_WORD;
                else if (line_phase == PH_ENV_WORD) line_phase = PH_NORMAL;
            end
            PH_NORMAL: begin
                if (c == CH_NUL) begin
                    if (arg_open) close_argument();
                    finish_line(KIND_DONE);
                end else if (is_blank(c)) begin
                    if (arg_open) close_argument();
                end else if (c == CH_SQ) begin
                    arg_open   = 1'b1;
                    line_phase = PH_SQ;
                end else if (c == CH_DQ) begin
                    arg_open   = 1'b1;
                    line_phase = PH_DQ;
                end else begin
                    arg_open = 1'b1;
                    push_beat(KIND_BYTE, c);
                end
            end
            PH_SQ: begin
                if (c == CH_NUL) finish_line(KIND_ERR);
                else if (c == CH_SQ) line_phase = PH_NORMAL;
                else push_beat(KIND_BYTE, c);
            end
            PH_DQ: begin
                if (c == CH_NUL) finish_line(KIND_ERR);
                else if (c == CH_DQ) line_phase = PH_NORMAL;
                else if (c == CH_BSL) line_phase = PH_DQ_ESC;
                else push_beat(KIND_BYTE, c);
            end
            PH_DQ_ESC: begin
                line_phase = PH_DQ;
                if (c == CH_NUL) begin
                    push_beat(KIND_BYTE, CH_BSL);
                    finish_line(KIND_ERR);
                end else if (c == CH_DQ || c == CH_BSL) begin
                    push_beat(KIND_BYTE, c);
                end else if (c == CH_LC_N) begin
                    push_beat(KIND_BYTE, CH_LF);
                end else if (c == CH_LC_T) begin
                    push_beat(KIND_BYTE, CH_TAB);
                end else begin
                    // unknown escape: keep both bytes
                    push_beat(KIND_BYTE, CH_BSL);
                    push_beat(KIND_BYTE, c);
                end
            end
            default: restart_line();
        endcase
        if (expected_beats.size() > queued)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                note_failure($sformatf("unexpected beat: kind %0d value %02h count %0d last %0b",
                                       m_kind, m_value, m_count, m_last));
            end else begin
                head_beat = expected_beats.pop_front();
                if (m_kind !== head_beat.kind || m_value !== head_beat.value ||
                    m_count !== head_beat.count || m_last !== head_beat.last)
                    note_failure($sformatf({"beat mismatch: expected kind %0d value %02h ",
                                            "count %0d last %0b, got kind %0d value %02h ",
                                            "count %0d last %0b"},
                                           head_beat.kind, head_beat.value, head_beat.count,
                                           head_beat.last, m_kind, m_value, m_count, m_last));
            end
        end
    end

    // result side: random gaps after each beat, plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            rx_hold_left = hold_request;
            hold_request = 0;
        end
        if (m_valid && m_ready)
            rx_gap_left = (rx_idle_max > 0) ? $urandom_range(0, rx_idle_max) : 0;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // valid is left high after a beat so that a back-to-back byte needs one assignment only
    task automatic send_byte(logic [7:0] c);
        int gap;
        gap = (tx_idle_max > 0) ? $urandom_range(0, tx_idle_max) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        do @(posedge aclk); while (!s_ready);
        split_byte(c);
        items_sent++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
    endtask

    // always wait for the clock before the first check so valid is not driven twice in one step
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_beats.size() != 0);
    endtask

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    function automatic void append_blanks(int n);
        repeat (n) line_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endfunction

    function automatic void append_escape(logic [7:0] c);
        line_bytes.push_back(CH_BSL);
        line_bytes.push_back(c);
    endfunction

    function automatic logic [7:0] any_byte_but(logic [7:0] x, logic [7:0] y);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == x || c == y);
        return c;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = any_byte_but(CH_SQ, CH_DQ);
        while (c == CH_SP || c == CH_TAB || c == CH_BSL);
        return c;
    endfunction

    function automatic void append_word(int n);
        repeat (n) line_bytes.push_back(plain_byte());
    endfunction

    function automatic void append_dq_item();
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
                0: append_escape(CH_DQ);
                1: append_escape(CH_BSL);
                2: append_escape(CH_LC_N);
                3: append_escape(CH_LC_T);
                default: append_escape(plain_byte());
            endcase
        end else begin
            line_bytes.push_back(any_byte_but(CH_DQ, CH_BSL));
        end
    endfunction

    function automatic void append_segment();
        case ($urandom_range(0, 2))
            0: append_word($urandom_range(1, 4));
            1: begin
                line_bytes.push_back(CH_SQ);
                repeat ($urandom_range(0, 4)) line_bytes.push_back(any_byte_but(CH_SQ, CH_SQ));
                line_bytes.push_back(CH_SQ);
            end
            default: begin
                line_bytes.push_back(CH_DQ);
                repeat ($urandom_range(0, 4)) append_dq_item();
                line_bytes.push_back(CH_DQ);
            end
        endcase
    endfunction

    function automatic void build_random_line();
        int style;
        int interp;
        int cut;
        line_bytes.delete();
        style = $urandom_range(0, 19);
        if (style == 0) begin
            // noise, zero bytes included
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (style == 1) begin
            if ($urandom_range(0, 1)) line_bytes.push_back(CH_HASH);
            line_bytes.push_back(8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 6)) line_bytes.push_back(any_byte_but(CH_NUL, CH_NUL));
        end else begin
            append_text("#!");
            append_blanks($urandom_range(0, 2));
            interp = $urandom_range(0, 4);
            case (interp)
                0: append_text("env");
                1: append_text("/usr/bin/env");
                2: append_text("/bin/envy");
                3: append_text("xenv");
                default: append_word($urandom_range(1, 6));
            endcase
            append_blanks($urandom_range(1, 2));
            if (interp <= 1) begin
                append_word($urandom_range(1, 4));
                append_blanks($urandom_range(1, 2));
            end
            repeat ($urandom_range(0, 4)) begin
                repeat ($urandom_range(1, 3)) append_segment();
                append_blanks($urandom_range(1, 2));
            end
            if (style == 3) begin
                case ($urandom_range(0, 2))
                    0: begin
                        line_bytes.push_back(CH_SQ);
                        repeat ($urandom_range(0, 3))
                            line_bytes.push_back(any_byte_but(CH_SQ, CH_SQ));
                    end
                    1: begin
                        line_bytes.push_back(CH_DQ);
                        repeat ($urandom_range(0, 3)) append_dq_item();
                    end
                    default: begin
                        line_bytes.push_back(CH_DQ);
                        repeat ($urandom_range(0, 3)) append_dq_item();
                        line_bytes.push_back(CH_BSL);
                    end
                endcase
            end else if ($urandom_range(0, 1)) begin
                append_segment();
            end
            if (style == 2) begin
                // end the line early, anywhere past the first byte
                cut = $urandom_range(1, line_bytes.size());
                while (line_bytes.size() > cut) void'(line_bytes.pop_back());
            end
        end
        line_bytes.push_back(CH_NUL);
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed_lines();
        tx_idle_max = 0;
        rx_idle_max = 0;
        // empty line, then a broken prefix whose tail is dropped up to the zero
        line_bytes = '{CH_NUL, CH_HASH, 8'hff, 8'h01, CH_NUL};
        send_line();
        line_bytes.delete();
        append_text("#! ");
        line_bytes.push_back(CH_NUL);
        append_text("#!\t env a 'b c' d");
        line_bytes.push_back(CH_NUL);
        append_text("#!x \"");
        append_escape(CH_LC_N);
        append_escape(CH_LC_T);
        append_escape(8'hff);
        append_escape(CH_DQ);
        append_escape(CH_BSL);
        line_bytes.push_back(CH_BSL);
        line_bytes.push_back(CH_NUL);
        send_line();
        wait_drained();
    endtask

    task automatic test_receiver_hold();
        tx_idle_max = 0;
        rx_idle_max = 0;
        line_bytes.delete();
        append_text("#!sh ");
        repeat (30) begin
            append_word(2);
            append_blanks(1);
        end
        line_bytes.push_back(CH_NUL);
        hold_request = 300;
        send_line();
        wait_drained();
    endtask

    task automatic test_count_saturation();
        tx_idle_max = 4;
        rx_idle_max = 4;
        line_bytes.delete();
        append_text("#!i ");
        repeat (257) begin
            append_word(1);
            append_blanks(1);
        end
        // leave the last argument open so the line end closes it at the cap
        append_word(1);
        line_bytes.push_back(CH_NUL);
        send_line();
        wait_drained();
    endtask

    task automatic test_random_lines();
        while (items_sent < ITEM_TARGET) begin
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            build_random_line();
            send_line();
            if ($urandom_range(0, 15) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_ch    = 8'h00;
        restart_line();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_lines();
        test_receiver_hold();
        test_count_saturation();
        test_random_lines();

        repeat (20) @(posedge aclk);
        if (failures == 0 && expected_beats.size() == 0) begin
            $display("[shebang_argument_splitter] OK");
        end else begin
            $display("[shebang_argument_splitter] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sas_pkg.sv
rtl/core/sas_front.sv
rtl/core/sas_queue.sv
rtl/core/sas_back.sv
rtl/core/shebang_argument_splitter.sv
tb/sv/testbench.sv
